### src/json_follower_field_extract_assert.svh
// Assertion macros shared by the checker of the follower field extractor.
// Depends on nothing; included by the checker file by bare name.
`ifndef JSON_FOLLOWER_FIELD_EXTRACT_ASSERT_SVH
`define JSON_FOLLOWER_FIELD_EXTRACT_ASSERT_SVH

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define JFFE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("jffe assertion failed");

// Antecedent holds in a cycle, consequent holds in the next one.
`define JFFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("jffe assertion failed");

`endif

### src/jffe_pkg.sv
// Package of the follower field extractor: request types, character codes,
// parser phase codes and the key text. Depends on nothing.
package jffe_pkg;

	localparam int unsigned KEY_LEN = 10;
	localparam int unsigned KEY_POS_W = 4;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_QUOTE = 8'h22;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_COLON = 8'h3A;

	localparam logic [2:0] PH_KEY  = 3'd0;
	localparam logic [2:0] PH_WS1  = 3'd1;
	localparam logic [2:0] PH_WS2  = 3'd2;
	localparam logic [2:0] PH_DIG  = 3'd3;
	localparam logic [2:0] PH_OK   = 3'd4;
	localparam logic [2:0] PH_FAIL = 3'd5;

	typedef struct packed {
		logic       en;
		logic       last;
		logic [7:0] text_byte;
	} jffe_step_t;

	typedef struct packed {
		logic        found;
		logic [31:0] follower_count;
	} jffe_result_t;

	function automatic logic [7:0] key_char(input logic [KEY_POS_W-1:0] pos);
		logic [7:0] c;
		unique case (pos)
			4'd0:    c = CHAR_QUOTE;
			4'd1:    c = 8'h66;
			4'd2:    c = 8'h6F;
			4'd3:    c = 8'h6C;
			4'd4:    c = 8'h6C;
			4'd5:    c = 8'h6F;
			4'd6:    c = 8'h77;
			4'd7:    c = 8'h65;
			4'd8:    c = 8'h72;
			4'd9:    c = CHAR_QUOTE;
			default: c = CHAR_NUL;
		endcase
		return c;
	endfunction

endpackage

### src/jffe_in_if.sv
// Input channel of the follower field extractor: one text byte per request.
// Depends on nothing.
interface jffe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       last_byte;

	modport source(output valid, output text_byte, output last_byte, input ready);
	modport sink(input valid, input text_byte, input last_byte, output ready);
endinterface

### src/jffe_out_if.sv
// Result channel of the follower field extractor: one request per buffer.
// Depends on nothing.
interface jffe_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [31:0] follower_count;

	modport source(output valid, output found, output follower_count, input ready);
	modport sink(input valid, input found, input follower_count, output ready);
endinterface

### src/jffe_digit_acc.sv
// Decimal accumulate step: value times ten plus one digit, with overflow flag.
// Depends on nothing.
module jffe_digit_acc (
	input  logic [31:0] acc,
	input  logic [3:0]  digit,
	output logic [31:0] sum,
	output logic        ovf
);
	logic [35:0] wide;

	assign wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, digit};
	assign sum  = wide[31:0];
	assign ovf  = |wide[35:32];
endmodule

### src/jffe_parser.sv
// Parser state and per-byte transition: key matcher, separator checks and
// digit accumulation. Depends on jffe_pkg and jffe_digit_acc.
module jffe_parser
	import jffe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  jffe_step_t   step,
	output jffe_result_t result
);
	logic [2:0]           phase_q;
	logic [KEY_POS_W-1:0] key_pos_q;
	logic [31:0]          acc_q;
	logic [2:0]           phase_d;
	logic [KEY_POS_W-1:0] key_pos_d;
	logic [31:0]          acc_d;
	logic [7:0]           b;
	logic                 b_space;
	logic                 b_digit;
	logic [3:0]           digit;
	logic [31:0]          acc_sum;
	logic                 acc_ovf;
	logic                 ok;

	assign b       = step.text_byte;
	assign b_space = (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_CR) || (b == CHAR_LF);
	assign b_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
	assign digit   = b[3:0];

	jffe_digit_acc u_acc (
		.acc   (acc_q),
		.digit (digit),
		.sum   (acc_sum),
		.ovf   (acc_ovf)
	);

	always_comb begin
		phase_d   = phase_q;
		key_pos_d = key_pos_q;
		acc_d     = acc_q;
		unique case (phase_q)
			PH_KEY: begin
				if (b == CHAR_NUL) begin
					phase_d = PH_FAIL;
				end else begin
					if (b == key_char(key_pos_q)) begin
						key_pos_d = key_pos_q + 1'b1;
					end else if (b == CHAR_QUOTE) begin
						key_pos_d = KEY_POS_W'(1);
					end else begin
						key_pos_d = '0;
					end
					if (key_pos_d == KEY_POS_W'(KEY_LEN)) begin
						phase_d = PH_WS1;
					end
				end
			end
			PH_WS1: begin
				if (!b_space) begin
					phase_d = (b == CHAR_COLON) ? PH_WS2 : PH_FAIL;
				end
			end
			PH_WS2: begin
				if (!b_space) begin
					if (b_digit) begin
						acc_d   = {28'd0, digit};
						phase_d = PH_DIG;
					end else begin
						phase_d = PH_FAIL;
					end
				end
			end
			PH_DIG: begin
				if (b_digit) begin
					if (acc_ovf) begin
						phase_d = PH_FAIL;
					end else begin
						acc_d = acc_sum;
					end
				end else begin
					phase_d = PH_OK;
				end
			end
			default: begin
			end
		endcase
	end

	assign ok                    = (phase_d == PH_DIG) || (phase_d == PH_OK);
	assign result.found          = ok;
	assign result.follower_count = ok ? acc_d : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_KEY;
			key_pos_q <= '0;
			acc_q     <= '0;
		end else if (step.en) begin
			if (step.last) begin
				phase_q   <= PH_KEY;
				key_pos_q <= '0;
				acc_q     <= '0;
			end else begin
				phase_q   <= phase_d;
				key_pos_q <= key_pos_d;
				acc_q     <= acc_d;
			end
		end
	end
endmodule

### src/json_follower_field_extract.sv
// Top level of the follower field extractor: input register, parser, result
// register. Depends on jffe_pkg, jffe_in_if, jffe_out_if and jffe_parser.
//
// The in channel takes one byte of a text buffer per request, with last_byte
// set on the final byte. The parser looks for the first quoted key
// "follower", then a colon and a decimal number, and a zero byte ends the scan.
// The out channel gives one request per buffer, after the byte marked last:
// found and follower_count, where follower_count is zero when found is low.
// A byte is registered on acceptance and parsed as it leaves the input register;
// the result of a buffer is then registered in the result register and shown on
// the out channel. One byte is accepted in every cycle, limited only by the result
// register: while a result waits, bytes that are not last keep flowing, and
// a last byte waits in the input register until the result is taken.
// Reset clears the parser to the start of a buffer and empties both registers.
module json_follower_field_extract
	import jffe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	jffe_in_if.sink     in,
	jffe_out_if.source  out
);
	logic         valid_s1;
	logic [7:0]   text_byte_s1;
	logic         last_s1;
	logic         go_s1;
	logic         out_valid_q;
	jffe_result_t result_q;
	jffe_result_t result;
	jffe_step_t   step;

	assign go_s1    = valid_s1 && !(last_s1 && out_valid_q && !out.ready);
	assign in.ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.ready) begin
			valid_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			text_byte_s1 <= in.text_byte;
			last_s1      <= in.last_byte;
		end
	end

	assign step.en        = go_s1;
	assign step.last      = last_s1;
	assign step.text_byte = text_byte_s1;

	jffe_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			result_q <= result;
		end
	end

	assign out.valid          = out_valid_q;
	assign out.found          = result_q.found;
	assign out.follower_count = result_q.follower_count;
endmodule

### src/jffe_checker.sv
// Port-level checker of the follower field extractor, bound to the top level.
// Depends on json_follower_field_extract_assert.svh.
`include "json_follower_field_extract_assert.svh"

module jffe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_found,
	input logic [31:0] out_follower_count
);
	`JFFE_ASSERT_NEXT(a_out_valid_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`JFFE_ASSERT_NEXT(a_out_data_hold, clk, arst_n, out_valid && !out_ready,
		$stable(out_found) && $stable(out_follower_count))
	`JFFE_ASSERT_SAME(a_not_found_zero, clk, arst_n, out_valid && !out_found,
		out_follower_count == 32'd0)
	`JFFE_ASSERT_SAME(a_result_follows_last, clk, arst_n, $rose(out_valid),
		$past(in_valid && in_ready && in_last_byte, 2))
endmodule

bind json_follower_field_extract jffe_checker u_jffe_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in.valid),
	.in_ready           (in.ready),
	.in_last_byte       (in.last_byte),
	.out_valid          (out.valid),
	.out_ready          (out.ready),
	.out_found          (out.found),
	.out_follower_count (out.follower_count)
);
